/* rtl/bpsm_pkg.sv */
// Shared types, constants and helpers of the buffer pool slot manager.
package bpsm_pkg;

  localparam int POOL_SLOTS = 16;
  localparam int KEY_BITS   = 32;

  localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
  localparam int KEY_W  = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int ADDR_W = 3;

  localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;
  localparam logic [31:0] GC_AGE_RST      = 32'd60;
  localparam logic [31:0] TICK_MAX        = 32'hFFFF_FFFF;

  // Commands.
  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_FIND    = 3'd1;
  localparam logic [2:0] CMD_RELEASE = 3'd2;
  localparam logic [2:0] CMD_TOUCH   = 3'd3;
  localparam logic [2:0] CMD_GC      = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_REUSED    = 3'd0;
  localparam logic [2:0] ST_CREATED   = 3'd1;
  localparam logic [2:0] ST_REPLACED  = 3'd2;
  localparam logic [2:0] ST_NOSPACE   = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;
  localparam logic [2:0] ST_NOTFOUND  = 3'd5;
  localparam logic [2:0] ST_TOUCHED   = 3'd6;
  localparam logic [2:0] ST_COLLECTED = 3'd7;

  // Configuration register indexes.
  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_GC_AGE      = 1'b1;

  typedef struct packed {
    logic [4:0]  max_entries;
    logic [31:0] gc_age;
  } cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              key_we;
    logic              stamp_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_key;
    logic [3:0]        wr_type;
    logic [31:0]       wr_stamp;
  } mem_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [3:0]       elem_type;
    logic [31:0]      stamp;
  } mem_rsp_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } pick_t;

  // Lowest set bit of a slot vector.
  function automatic pick_t lowest_set(input logic [POOL_SLOTS-1:0] vec);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        p.found = 1'b1;
        p.idx   = SLOT_W'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [4:0] sat5(input logic [CNT_W-1:0] v);
    if (32'(v) > 32'd31) begin
      return 5'd31;
    end else begin
      return 5'(v);
    end
  endfunction

endpackage

/* rtl/bpsm_if.sv */
// Request and response channel interfaces of the buffer pool slot manager.
interface bpsm_req_if import bpsm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] shape_key;
  logic [3:0]  elem_type;
  logic [3:0]  handle;
  logic        handle_present;

  modport source (output valid, cmd, shape_key, elem_type, handle, handle_present,
                  input ready);
  modport sink (input valid, cmd, shape_key, elem_type, handle, handle_present,
                output ready);
endinterface

interface bpsm_rsp_if import bpsm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] slot;
  logic [2:0] status;
  logic [4:0] free_count;
  logic [4:0] used_count;
  logic [4:0] removed_count;

  modport source (output valid, slot, status, free_count, used_count, removed_count,
                  input ready);
  modport sink (input valid, slot, status, free_count, used_count, removed_count,
                output ready);
endinterface

/* rtl/bpsm_cfg.sv */
// APB configuration registers: occupancy limit and garbage collection age.
module bpsm_cfg import bpsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic reg_idx;
  logic wr_en;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_entries <= MAX_ENTRIES_RST;
      cfg.gc_age      <= GC_AGE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_ENTRIES: cfg.max_entries <= pwdata[4:0];
        REG_GC_AGE:      cfg.gc_age      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_ENTRIES: prdata = {27'd0, cfg.max_entries};
      REG_GC_AGE:      prdata = cfg.gc_age;
      default:         prdata = '0;
    endcase
  end

endmodule

/* rtl/bpsm_store.sv */
// Slot payload memories: key and type in one, last-use stamp in the other.
module bpsm_store import bpsm_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [KEY_W+3:0] key_mem   [POOL_SLOTS];
  logic [31:0]      stamp_mem [POOL_SLOTS];

  always_ff @(posedge clk) begin
    if (req.key_we) begin
      key_mem[req.wr_addr] <= {req.wr_type, req.wr_key};
    end
    if (req.stamp_we) begin
      stamp_mem[req.wr_addr] <= req.wr_stamp;
    end
    {rsp.elem_type, rsp.key} <= key_mem[req.rd_addr];
    rsp.stamp                <= stamp_mem[req.rd_addr];
  end

endmodule

/* rtl/bpsm_engine.sv */
// Command sequencer: slot state flags, counters, memory scan and result register.
module bpsm_engine import bpsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  bpsm_req_if.sink  req,
  bpsm_rsp_if.source rsp,
  output mem_req_t  mem_req,
  input  mem_rsp_t  mem_rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

  logic [1:0]            state;
  logic [2:0]            c_cmd;
  logic [KEY_W-1:0]      c_key;
  logic [3:0]            c_type;
  logic [SLOT_W-1:0]     c_hidx;
  logic                  c_hit;
  logic                  c_present;
  logic [SLOT_W-1:0]     iss_idx;
  logic                  iss_on;
  logic                  rd_vld;
  logic [SLOT_W-1:0]     rd_idx;
  logic                  match_found;
  logic [SLOT_W-1:0]     match_idx;
  logic [31:0]           thr;
  logic [31:0]           now_tick;
  logic [CNT_W-1:0]      removed;
  logic [CNT_W-1:0]      used_cnt;
  logic [CNT_W-1:0]      free_cnt;
  logic [POOL_SLOTS-1:0] slot_valid;
  logic [POOL_SLOTS-1:0] slot_busy;
  logic                  out_valid;
  logic [3:0]            out_slot;
  logic [2:0]            out_status;
  logic [4:0]            out_free;
  logic [4:0]            out_used;
  logic [4:0]            out_removed;

  logic                  req_fire;
  logic                  h_in_range;
  logic                  rd_free;
  logic                  key_match;
  logic                  gc_kill;
  logic                  fin_go;
  pick_t                 empty_pick;
  pick_t                 free_pick;

  // Finish-step decision.
  logic                  f_grant;
  logic                  f_set_valid;
  logic                  f_clr_busy;
  logic                  f_wr_key;
  logic                  f_wr_stamp;
  logic [SLOT_W-1:0]     f_idx;
  logic [2:0]            f_status;
  logic [CNT_W-1:0]      used_next;
  logic [CNT_W-1:0]      free_next;

  assign req.ready  = (state == S_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign h_in_range = 32'(req.handle) < POOL_SLOTS;

  assign rd_free   = slot_valid[rd_idx] && !slot_busy[rd_idx];
  assign key_match = (mem_rsp.key == c_key) && (mem_rsp.elem_type == c_type);
  assign gc_kill   = rd_vld && (c_cmd == CMD_GC) && rd_free && (mem_rsp.stamp < thr);

  assign fin_go     = (state == S_FIN) && (!out_valid || rsp.ready);
  assign empty_pick = lowest_set(~slot_valid);
  assign free_pick  = lowest_set(slot_valid & ~slot_busy);

  always_comb begin
    f_grant     = 1'b0;
    f_set_valid = 1'b0;
    f_clr_busy  = 1'b0;
    f_wr_key    = 1'b0;
    f_wr_stamp  = 1'b0;
    f_idx       = '0;
    f_status    = ST_NOTFOUND;
    used_next   = used_cnt;
    free_next   = free_cnt;
    case (c_cmd)
      CMD_ALLOC, CMD_FIND: begin
        if (match_found) begin
          f_grant    = 1'b1;
          f_wr_stamp = 1'b1;
          f_idx      = match_idx;
          f_status   = ST_REUSED;
          free_next  = free_cnt - CNT_W'(1);
        end else if ((32'(used_cnt) < 32'(cfg.max_entries)) && empty_pick.found) begin
          f_grant     = 1'b1;
          f_set_valid = 1'b1;
          f_wr_key    = 1'b1;
          f_wr_stamp  = 1'b1;
          f_idx       = empty_pick.idx;
          f_status    = ST_CREATED;
          used_next   = used_cnt + CNT_W'(1);
        end else if ((c_cmd == CMD_ALLOC) && free_pick.found) begin
          f_grant    = 1'b1;
          f_wr_key   = 1'b1;
          f_wr_stamp = 1'b1;
          f_idx      = free_pick.idx;
          f_status   = ST_REPLACED;
          free_next  = free_cnt - CNT_W'(1);
        end else begin
          f_status = ST_NOSPACE;
        end
      end
      CMD_RELEASE: begin
        if (c_present && c_hit) begin
          f_clr_busy = 1'b1;
          f_wr_stamp = 1'b1;
          f_idx      = c_hidx;
          f_status   = ST_RELEASED;
          if (slot_busy[c_hidx]) begin
            free_next = free_cnt + CNT_W'(1);
          end
        end
      end
      CMD_TOUCH: begin
        if (c_hit) begin
          f_wr_stamp = 1'b1;
          f_idx      = c_hidx;
          f_status   = ST_TOUCHED;
        end
      end
      CMD_GC: begin
        f_status = ST_COLLECTED;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_req.rd_addr  = iss_idx;
    mem_req.key_we   = fin_go && f_wr_key;
    mem_req.stamp_we = fin_go && f_wr_stamp;
    mem_req.wr_addr  = f_idx;
    mem_req.wr_key   = c_key;
    mem_req.wr_type  = c_type;
    mem_req.wr_stamp = now_tick;
  end

  // Threshold is a registered function of the tick counter; it is current by the time the first scan data arrives.
  always_ff @(posedge clk) begin
    thr <= (now_tick > cfg.gc_age) ? (now_tick - cfg.gc_age) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      iss_on      <= 1'b0;
      rd_vld      <= 1'b0;
      now_tick    <= '0;
      used_cnt    <= '0;
      free_cnt    <= '0;
      slot_valid  <= '0;
      slot_busy   <= '0;
      out_valid   <= 1'b0;
      match_found <= 1'b0;
      removed     <= '0;
    end else begin
      rd_vld <= iss_on;
      rd_idx <= iss_idx;
      if (iss_on) begin
        iss_idx <= iss_idx + SLOT_W'(1);
        if (iss_idx == LAST_SLOT) begin
          iss_on <= 1'b0;
        end
      end
      if (rsp.ready && !fin_go) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_fire) begin
            c_cmd       <= req.cmd;
            c_key       <= req.shape_key[KEY_W-1:0];
            c_type      <= req.elem_type;
            c_hidx      <= SLOT_W'(req.handle);
            c_hit       <= h_in_range && slot_valid[SLOT_W'(req.handle)];
            c_present   <= req.handle_present;
            match_found <= 1'b0;
            removed     <= '0;
            iss_idx     <= '0;
            if (((req.cmd == CMD_ALLOC) || (req.cmd == CMD_GC)) && (now_tick != TICK_MAX)) begin
              now_tick <= now_tick + 32'd1;
            end
            if ((req.cmd == CMD_ALLOC) || (req.cmd == CMD_FIND) || (req.cmd == CMD_GC)) begin
              iss_on <= 1'b1;
              state  <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (rd_vld) begin
            if (gc_kill) begin
              slot_valid[rd_idx] <= 1'b0;
              removed            <= removed + CNT_W'(1);
              used_cnt           <= used_cnt - CNT_W'(1);
              free_cnt           <= free_cnt - CNT_W'(1);
            end
            if ((c_cmd != CMD_GC) && rd_free && key_match && !match_found) begin
              match_found <= 1'b1;
              match_idx   <= rd_idx;
            end
            if (rd_idx == LAST_SLOT) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (fin_go) begin
            if (f_set_valid) begin
              slot_valid[f_idx] <= 1'b1;
            end
            if (f_grant) begin
              slot_busy[f_idx] <= 1'b1;
            end
            if (f_clr_busy) begin
              slot_busy[f_idx] <= 1'b0;
            end
            used_cnt    <= used_next;
            free_cnt    <= free_next;
            out_valid   <= 1'b1;
            out_slot    <= 4'(f_idx);
            out_status  <= f_status;
            out_free    <= sat5(free_next);
            out_used    <= sat5(used_next);
            out_removed <= sat5(removed);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.slot          = out_slot;
  assign rsp.status        = out_status;
  assign rsp.free_count    = out_free;
  assign rsp.used_count    = out_used;
  assign rsp.removed_count = out_removed;

  a_used_matches: assert property (@(posedge clk) disable iff (rst)
    32'(used_cnt) == $countones(slot_valid))
    else $error("used counter differs from occupied slot flags");

  a_free_matches: assert property (@(posedge clk) disable iff (rst)
    32'(free_cnt) == $countones(slot_valid & ~slot_busy))
    else $error("free counter differs from free slot flags");

  a_busy_occupied: assert property (@(posedge clk) disable iff (rst)
    (slot_busy & ~slot_valid) == '0)
    else $error("busy flag set on an empty slot");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == S_SCAN))
    else $error("memory read data returned outside a scan");

endmodule

/* rtl/buffer_pool_slot_manager.sv */
// Top level of the buffer pool slot manager.
// Commands arrive as beats on req (valid/ready); each produces exactly one
// result beat on rsp carrying the slot, a status code and the free, used and
// removed counts after the command. Two registers sit on an APB port:
// max_entries at byte address 0 and gc_age at byte address 4; write them
// only while no command is in flight.
// Allocate, find-or-create and garbage collect walk the slot memories one
// entry per cycle before presenting their result. Release, touch and unknown
// commands skip the scan and go straight to the finishing step. The next
// request is taken the cycle after a result is loaded. One command is
// handled at a time: the scan of the slot memory read port sets the rate.
// Memory writes only happen in the finishing cycle, so a scan never
// overlaps a write.
// A finished result sits in an output register and the next request is
// taken while it waits; if rsp stalls, the following command completes its
// work and then holds in its final step until the result register drains.
// Reset empties every slot, zeroes the tick counter and loads the default
// register values; the slot memories need no clearing.
module buffer_pool_slot_manager import bpsm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bpsm_req_if.sink          req,
  bpsm_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg;
  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  bpsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpsm_store u_store (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  bpsm_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .req     (req),
    .rsp     (rsp),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

endmodule
